>>> sv/sync_length_crc_deframer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sync, length and CRC frame receiver
// Each macro checks a property on the rising edge of i_clk while i_rst_n is
// high. The macros expand to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CRC_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_CRC_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

`define SLCD_ASSERT_SAME(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("slcd assertion failed");

`define SLCD_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("slcd assertion failed");

`else

`define SLCD_ASSERT_SAME(lbl, ant, con)

`define SLCD_ASSERT_NEXT(lbl, ant, con)

`endif

`endif

>>> sv/slcd_pkg.sv
// ---------------------------------------------------------------------------
// slcd_pkg
// Types, codes and the CRC-16/XMODEM byte update shared by the frame
// receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package slcd_pkg;

    localparam int unsigned MAX_LEN_DEFAULT = 256;
    localparam int unsigned CFG_INDEX_W     = 1;
    localparam int unsigned CFG_DATA_W      = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 1'd1;

    localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hFA;
    localparam logic [7:0]  SYNC_SECOND_RESET = 8'hFF;
    localparam logic [15:0] MIN_LEN           = 16'd3;
    localparam logic [15:0] CRC_BYTES         = 16'd2;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_BODY   = 3'd3,
        PH_CRC_LO = 3'd4,
        PH_CRC_HI = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BODY = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_REJ  = 2'd3
    } t_kind;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] position;
    } t_result;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = {crc[7:0], crc[15:8]};
        c = c ^ {8'h00, b};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/slcd_in_if.sv
// ---------------------------------------------------------------------------
// slcd_in_if
// Received byte channel with valid and ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface slcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> sv/slcd_out_if.sv
// ---------------------------------------------------------------------------
// slcd_out_if
// Result channel with valid and ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface slcd_out_if;
    logic            valid;
    logic            ready;
    slcd_pkg::t_kind kind;
    logic [7:0]      data;
    logic [7:0]      position;

    modport source (output valid, output kind, output data, output position, input ready);
    modport sink   (input valid, input kind, input data, input position, output ready);
endinterface

`default_nettype wire

>>> sv/slcd_parser.sv
// ---------------------------------------------------------------------------
// slcd_parser
// Frame state machine: sync hunt, length capture, body pass-through with a
// running CRC and the final CRC check. State moves on each step.
// ---------------------------------------------------------------------------
`default_nettype none

module slcd_parser #(
    parameter int unsigned MAX_LEN = slcd_pkg::MAX_LEN_DEFAULT
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_byte,
    input  wire logic [7:0]      i_sync_first,
    input  wire logic [7:0]      i_sync_second,
    output slcd_pkg::t_result    o_result
);

    slcd_pkg::t_phase r_phase,         n_phase;
    logic [7:0]       r_previous_byte, n_previous_byte;
    logic [15:0]      r_frame_length,  n_frame_length;
    logic [15:0]      r_byte_count,    n_byte_count;
    logic [15:0]      r_running_crc,   n_running_crc;
    logic [7:0]       r_crc_low_byte,  n_crc_low_byte;

    logic [15:0] w_length;
    logic [15:0] w_count_inc;

    assign w_length    = {i_byte, r_frame_length[7:0]};
    assign w_count_inc = r_byte_count + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= slcd_pkg::PH_HUNT;
            r_previous_byte <= 8'd0;
            r_frame_length  <= 16'd0;
            r_byte_count    <= 16'd0;
            r_running_crc   <= 16'd0;
            r_crc_low_byte  <= 8'd0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_previous_byte <= n_previous_byte;
            r_frame_length  <= n_frame_length;
            r_byte_count    <= n_byte_count;
            r_running_crc   <= n_running_crc;
            r_crc_low_byte  <= n_crc_low_byte;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_previous_byte = r_previous_byte;
        n_frame_length  = r_frame_length;
        n_byte_count    = r_byte_count;
        n_running_crc   = r_running_crc;
        n_crc_low_byte  = r_crc_low_byte;
        o_result        = '{valid: 1'b0, kind: slcd_pkg::KIND_BODY,
                            data: 8'd0, position: 8'd0};
        case (r_phase)
            slcd_pkg::PH_LEN_LO: begin
                n_frame_length = {8'd0, i_byte};
                n_phase        = slcd_pkg::PH_LEN_HI;
            end
            slcd_pkg::PH_LEN_HI: begin
                n_frame_length = w_length;
                if (w_length < slcd_pkg::MIN_LEN || w_length > 16'(MAX_LEN)) begin
                    n_phase         = slcd_pkg::PH_HUNT;
                    n_previous_byte = 8'd0;
                    o_result.valid  = 1'b1;
                    o_result.kind   = slcd_pkg::KIND_REJ;
                end else begin
                    n_byte_count  = 16'd0;
                    n_running_crc = 16'd0;
                    n_phase       = slcd_pkg::PH_BODY;
                end
            end
            slcd_pkg::PH_BODY: begin
                n_running_crc     = slcd_pkg::crc_step(r_running_crc, i_byte);
                n_byte_count      = w_count_inc;
                if (w_count_inc >= r_frame_length - slcd_pkg::CRC_BYTES) begin
                    n_phase = slcd_pkg::PH_CRC_LO;
                end
                o_result.valid    = 1'b1;
                o_result.kind     = slcd_pkg::KIND_BODY;
                o_result.data     = i_byte;
                o_result.position = r_byte_count[7:0];
            end
            slcd_pkg::PH_CRC_LO: begin
                n_crc_low_byte = i_byte;
                n_phase        = slcd_pkg::PH_CRC_HI;
            end
            slcd_pkg::PH_CRC_HI: begin
                n_phase         = slcd_pkg::PH_HUNT;
                n_previous_byte = 8'd0;
                o_result.valid  = 1'b1;
                o_result.kind   = ({i_byte, r_crc_low_byte} == r_running_crc)
                                  ? slcd_pkg::KIND_GOOD : slcd_pkg::KIND_BAD;
            end
            default: begin
                n_phase = slcd_pkg::PH_HUNT;
                if (r_previous_byte == i_sync_first && i_byte == i_sync_second) begin
                    n_phase         = slcd_pkg::PH_LEN_LO;
                    n_previous_byte = 8'd0;
                end else begin
                    n_previous_byte = i_byte;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/slcd_out_stage.sv
// ---------------------------------------------------------------------------
// slcd_out_stage
// Result register in front of the output channel. It reports whether it can
// take a new result in the current cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module slcd_out_stage (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_load,
    input  slcd_pkg::t_result i_result,
    output logic              o_free,
    slcd_out_if.source        o_res
);

    logic            r_valid;
    slcd_pkg::t_kind r_kind;
    logic [7:0]      r_data;
    logic [7:0]      r_position;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_result.valid;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind     <= i_result.kind;
            r_data     <= i_result.data;
            r_position <= i_result.position;
        end
    end

    assign o_res.valid    = r_valid;
    assign o_res.kind     = r_kind;
    assign o_res.data     = r_data;
    assign o_res.position = r_position;

endmodule

`default_nettype wire

>>> sv/sync_length_crc_deframer.sv
// ---------------------------------------------------------------------------
// sync_length_crc_deframer
// Hunts a byte stream for a sync pair, reads a little-endian length, passes
// the body bytes on with their offsets and checks a CRC-16/XMODEM trailer.
//
//   Channel   Direction  Payload
//   i_rx      in         rx_byte
//   o_res     out        kind, data, position
//   i_cfg_*   in         sync_first (index 0), sync_second (index 1)
//
// A byte goes through an input register and the frame state machine into
// the result register, which drives o_res.valid.
// One byte is accepted every cycle while no result stalls; the state
// machine step sets that rate. Reset is synchronous; there is no clearing
// pass. A stalled result holds the state machine; input is then accepted
// only while the input register is empty.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sync_length_crc_deframer_macros.svh"

module sync_length_crc_deframer #(
    parameter int unsigned MAX_LEN = slcd_pkg::MAX_LEN_DEFAULT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [slcd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [slcd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    slcd_in_if.sink                               i_rx,
    slcd_out_if.source                            o_res
);

    logic [7:0] r_sync_first_q;
    logic [7:0] r_sync_second;
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;

    logic              w_advance;
    logic              w_out_free;
    slcd_pkg::t_result w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first_q <= slcd_pkg::SYNC_FIRST_RESET;
            r_sync_second  <= slcd_pkg::SYNC_SECOND_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                slcd_pkg::CFG_SYNC_FIRST: begin
                    r_sync_first_q <= i_cfg_data;
                end
                slcd_pkg::CFG_SYNC_SECOND: begin
                    r_sync_second <= i_cfg_data;
                end
                default: begin
                    r_sync_second <= r_sync_second;
                end
            endcase
        end
    end

    assign w_advance  = r_in_valid && w_out_free;
    assign i_rx.ready = !r_in_valid || w_out_free;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_rx.valid && i_rx.ready) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    slcd_parser #(
        .MAX_LEN(MAX_LEN)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_advance),
        .i_byte       (r_in_byte),
        .i_sync_first (r_sync_first_q),
        .i_sync_second(r_sync_second),
        .o_result     (w_result)
    );

    slcd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance),
        .i_result(w_result),
        .o_free  (w_out_free),
        .o_res   (o_res)
    );

    `SLCD_ASSERT_SAME(a_in_full_blocks, r_in_valid && !w_out_free, !i_rx.ready)
    `SLCD_ASSERT_NEXT(a_result_lands, w_advance && w_result.valid, o_res.valid)
    `SLCD_ASSERT_SAME(a_status_zero, o_res.valid && o_res.kind != slcd_pkg::KIND_BODY, o_res.data == 8'd0 && o_res.position == 8'd0)

endmodule

`default_nettype wire

>>> test/slcd_tb_pkg.sv
// ---------------------------------------------------------------------------
// slcd_tb_pkg
// Byte list type and a bitwise CRC-16/XMODEM update, used by the stimulus
// to build frames and by the checker to predict the verdict of each frame.
// ---------------------------------------------------------------------------
package slcd_tb_pkg;

    typedef logic [7:0] t_bytes[$];

    // Polynomial 0x1021, MSB first, one bit per iteration.
    function automatic logic [15:0] crc16_xmodem_byte(input logic [15:0] acc,
                                                      input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> test/slcd_checker.sv
// ---------------------------------------------------------------------------
// slcd_checker
// Watches the byte and result channels of the frame receiver, follows the
// sync register writes, predicts every result from the accepted bytes and
// compares each result transaction with the oldest prediction.
// ---------------------------------------------------------------------------
module slcd_checker
    import slcd_pkg::*;
    import slcd_tb_pkg::*;
#(
    parameter int unsigned MAX_LEN = slcd_pkg::MAX_LEN_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    slcd_in_if                     i_rx,
    slcd_out_if                    i_res,
    output int                     o_mismatches,
    output int                     o_pending,
    output int                     o_good_frames,
    output int                     o_bad_frames,
    output int                     o_rejected,
    output int                     o_body_bytes
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] position;
    } t_deframed;

    t_deframed   expected_results[$];
    int          mismatch_count;

    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    t_phase      rx_phase;
    logic [7:0]  last_hunt_byte;
    logic [15:0] frame_len;
    logic [15:0] body_count;
    logic [15:0] body_crc;
    logic [7:0]  trailer_lo;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic deframe_byte(input logic [7:0] b, output logic produced,
                                output t_deframed r);
        produced = 1'b0;
        r = '{KIND_BODY, 8'h00, 8'h00};
        case (rx_phase)
            PH_LEN_LO: begin
                frame_len = {8'h00, b};
                rx_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                frame_len[15:8] = b;
                if (frame_len < MIN_LEN || frame_len > MAX_LEN) begin
                    produced = 1'b1;
                    r.kind = KIND_REJ;
                    rx_phase = PH_HUNT;
                    last_hunt_byte = 8'h00;
                end else begin
                    body_count = '0;
                    body_crc = '0;
                    rx_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                produced = 1'b1;
                r = '{KIND_BODY, b, body_count[7:0]};
                body_crc = crc16_xmodem_byte(body_crc, b);
                body_count = body_count + 16'd1;
                if (body_count >= frame_len - CRC_BYTES) begin
                    rx_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                trailer_lo = b;
                rx_phase = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                produced = 1'b1;
                r.kind = ({b, trailer_lo} == body_crc) ? KIND_GOOD : KIND_BAD;
                rx_phase = PH_HUNT;
                last_hunt_byte = 8'h00;
            end
            default: begin
                rx_phase = PH_HUNT;
                if (last_hunt_byte == sync_first && b == sync_second) begin
                    rx_phase = PH_LEN_LO;
                    last_hunt_byte = 8'h00;
                end else begin
                    last_hunt_byte = b;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        logic      produced;
        t_deframed predicted;
        t_deframed seen;
        t_deframed want;
        if (!i_rst_n) begin
            sync_first = SYNC_FIRST_RESET;
            sync_second = SYNC_SECOND_RESET;
            rx_phase = PH_HUNT;
            last_hunt_byte = 8'h00;
            frame_len = '0;
            body_count = '0;
            body_crc = '0;
            trailer_lo = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SYNC_FIRST:  sync_first = i_cfg_data;
                    CFG_SYNC_SECOND: sync_second = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_rx.valid && i_rx.ready) begin
                deframe_byte(i_rx.rx_byte, produced, predicted);
                if (produced) begin
                    expected_results.push_back(predicted);
                end
            end
            if (i_res.valid && i_res.ready) begin
                seen = '{i_res.kind, i_res.data, i_res.position};
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result kind %0d data 0x%02h with none expected",
                                              seen.kind, seen.data));
                end else begin
                    want = expected_results.pop_front();
                    if (seen.kind !== want.kind) begin
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  seen.kind, want.kind));
                    end
                    if (seen.data !== want.data) begin
                        report_mismatch($sformatf("data 0x%02h, expected 0x%02h",
                                                  seen.data, want.data));
                    end
                    if (seen.position !== want.position) begin
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  seen.position, want.position));
                    end
                    case (want.kind)
                        KIND_BODY: o_body_bytes <= o_body_bytes + 1;
                        KIND_GOOD: o_good_frames <= o_good_frames + 1;
                        KIND_BAD:  o_bad_frames <= o_bad_frames + 1;
                        default:   o_rejected <= o_rejected + 1;
                    endcase
                end
            end
        end
        o_pending <= expected_results.size();
    end

    initial begin
        mismatch_count = 0;
        o_pending = 0;
        o_good_frames = 0;
        o_bad_frames = 0;
        o_rejected = 0;
        o_body_bytes = 0;
    end

endmodule

>>> test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Drives the frame receiver with a serial byte stream: a short directed
// run of edge cases, then random frames, bad lengths and noise under six
// sync settings, with random gaps on both channels except in one quiet run.
// A checker beside the block predicts and compares every result; this
// module gives the verdict.
module tb_top;
    import slcd_pkg::*;
    import slcd_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_LEN      = slcd_pkg::MAX_LEN_DEFAULT;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 400000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    slcd_in_if  rx_ch ();
    slcd_out_if res_ch ();

    int mismatches;
    int pending;
    int good_frames;
    int bad_frames;
    int rejected;
    int body_bytes;

    int         cycles;
    int         bytes_sent;
    int         settings_used;
    bit         quiet;
    logic [7:0] sync_a;
    logic [7:0] sync_b;

    sync_length_crc_deframer #(.MAX_LEN(MAX_LEN)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_ch),
        .o_res      (res_ch)
    );

    slcd_checker #(.MAX_LEN(MAX_LEN)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_rx         (rx_ch),
        .i_res        (res_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_good_frames(good_frames),
        .o_bad_frames (bad_frames),
        .o_rejected   (rejected),
        .o_body_bytes (body_bytes)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, pending);
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= quiet || ($urandom_range(99) >= 14);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(99) < 14) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [15:0] len, input bit lone);
        if (!lone) send_byte(sync_a);
        send_byte(sync_b);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
    endtask

    task automatic send_frame(input t_bytes body, input bit corrupt, input bit lone);
        logic [15:0] crc;
        crc = '0;
        send_header(16'(body.size() + 2), lone);
        foreach (body[i]) begin
            crc = crc16_xmodem_byte(crc, body[i]);
            send_byte(body[i]);
        end
        if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(15));
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
    endtask

    function automatic t_bytes random_body(input int n);
        t_bytes q;
        for (int i = 0; i < n; i++) q.push_back(8'($urandom));
        return q;
    endfunction

    // Mostly short bodies, a few long ones, now and then the longest allowed.
    function automatic int random_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3) return MAX_LEN;
        if (pick < 8) return $urandom_range(65, MAX_LEN - 1);
        if (pick < 25) return $urandom_range(13, 64);
        return $urandom_range(3, 12);
    endfunction

    function automatic logic [15:0] bad_length();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(2));
            1:       return 16'(MAX_LEN + 1);
            2:       return 16'($urandom_range(MAX_LEN + 2, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_traffic(input int quota);
        int stop;
        int pick;
        stop = bytes_sent + quota;
        while (bytes_sent < stop) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_frame(random_body(random_length() - 2), $urandom_range(9) == 0, 1'b0);
            end else if (pick < 87) begin
                send_header(bad_length(), 1'b0);
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        end
        // Closing with a frame leaves the receiver hunting with a clear window.
        send_frame(random_body($urandom_range(1, 8)), 1'b0, 1'b0);
    endtask

    task automatic settle();
        rx_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_sync(input logic [7:0] first, input logic [7:0] second);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_SYNC_FIRST;
        i_cfg_data <= first;
        @(posedge i_clk);
        i_cfg_index <= CFG_SYNC_SECOND;
        i_cfg_data <= second;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sync_a = first;
        sync_b = second;
        settings_used++;
    endtask

    initial begin
        t_bytes body;
        cycles = 0;
        bytes_sent = 0;
        settings_used = 1;
        quiet = 1'b0;
        sync_a = SYNC_FIRST_RESET;
        sync_b = SYNC_SECOND_RESET;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_SYNC_FIRST;
        i_cfg_data <= '0;
        rx_ch.valid <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases under the reset sync pair.
        body = {8'h00};
        send_frame(body, 1'b0, 1'b0);
        body = {8'hFF, 8'h00};
        send_frame(body, 1'b1, 1'b0);
        send_header(16'd2, 1'b0);
        send_header(16'(MAX_LEN + 1), 1'b0);
        // The rejected length ends on the first sync byte; the second must not sync.
        send_header({sync_a, 8'h00}, 1'b0);
        send_byte(sync_b);
        send_frame(random_body(3), 1'b0, 1'b0);
        send_frame(random_body(MAX_LEN - 2), 1'b0, 1'b0);
        run_traffic(200);
        settle();

        // With a zero first sync byte, a lone second byte opens a frame.
        set_sync(8'h00, 8'h00);
        send_frame(random_body(2), 1'b0, 1'b1);
        run_traffic(200);
        settle();

        set_sync(8'hFF, 8'hFF);
        quiet = 1'b1;
        run_traffic(200);
        settle();
        quiet = 1'b0;

        set_sync(8'h00, 8'hFF);
        send_frame(random_body(4), 1'b0, 1'b1);
        run_traffic(150);
        settle();

        set_sync(8'hFF, 8'h00);
        run_traffic(150);
        settle();

        set_sync(8'($urandom), 8'($urandom));
        run_traffic(150);
        settle();

        $display("Sent %0d bytes under %0d sync settings; %0d body bytes passed on.",
                 bytes_sent, settings_used, body_bytes);
        $display("Frames: %0d good, %0d CRC mismatches, %0d lengths rejected.",
                 good_frames, bad_frames, rejected);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
